/* sv/sacd_pkg.sv */
// shared types and codes for the cache tag directory
`timescale 1ns / 1ps
package sacd_pkg;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_NOP   = 2'd3;

	localparam logic [2:0] CFG_OFFSET_BITS = 3'd0;
	localparam logic [2:0] CFG_SET_BITS    = 3'd1;
	localparam logic [2:0] CFG_WAYS        = 3'd2;
	localparam logic [2:0] CFG_LRU         = 3'd3;
	localparam logic [2:0] CFG_PREFETCH    = 3'd4;

	typedef enum logic [3:0] {
		ST_SWEEP = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_LOOK  = 4'b0100,
		ST_PLOOK = 4'b1000
	} state_t;

	// effective associativity fits 5 bits for up to 16 ways
	typedef struct packed {
		logic       refresh;
		logic [4:0] ways;
	} lkp_ctl_t;

endpackage

/* sv/sacd_ram.sv */
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module sacd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* sv/sacd_way_update.sv */
// tag compare, victim choice and age update for one set row
`timescale 1ns / 1ps
module sacd_way_update #(
	parameter int WAYS      = 8,
	parameter int ADDR_BITS = 48,
	parameter int AGE_W     = 3
) (
	input  sacd_pkg::lkp_ctl_t                 ctl,
	input  logic [ADDR_BITS-1:0]               tag,
	input  logic [WAYS-1:0]                    valid_in,
	input  logic [WAYS-1:0][ADDR_BITS-1:0]     tag_in,
	input  logic [WAYS-1:0][AGE_W-1:0]         age_in,
	output logic                               hit,
	output logic [WAYS-1:0]                    valid_out,
	output logic [WAYS-1:0][ADDR_BITS-1:0]     tag_out,
	output logic [WAYS-1:0][AGE_W-1:0]         age_out
);
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [WAYS-1:0]  in_use;
	logic [WAYS-1:0]  hit_vec;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] inv_way;
	logic             any_inv;
	logic [WAY_W-1:0] old_way;
	logic [AGE_W-1:0] old_age_best;
	logic [WAY_W-1:0] sel;
	logic             was_valid;
	logic [AGE_W-1:0] sel_age;
	logic             do_touch;

	always_comb begin
		for (int j = 0; j < WAYS; j++) begin
			in_use[j]  = 5'(j) < ctl.ways;
			hit_vec[j] = in_use[j] && valid_in[j] && (tag_in[j] == tag);
		end
		hit = |hit_vec;

		// lowest matching and lowest invalid way
		hit_way = '0;
		inv_way = '0;
		any_inv = 1'b0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_way = WAY_W'(j);
			end
			if (in_use[j] && !valid_in[j]) begin
				inv_way = WAY_W'(j);
				any_inv = 1'b1;
			end
		end

		// oldest way, ties go to the highest way
		old_way      = '0;
		old_age_best = age_in[0];
		for (int j = 0; j < WAYS; j++) begin
			if (in_use[j] && age_in[j] >= old_age_best) begin
				old_way      = WAY_W'(j);
				old_age_best = age_in[j];
			end
		end

		if (hit) begin
			sel = hit_way;
		end else if (any_inv) begin
			sel = inv_way;
		end else begin
			sel = old_way;
		end
		do_touch  = !hit || ctl.refresh;
		was_valid = valid_in[sel];
		sel_age   = age_in[sel];

		valid_out = valid_in;
		tag_out   = tag_in;
		age_out   = age_in;
		if (do_touch) begin
			for (int j = 0; j < WAYS; j++) begin
				if (WAY_W'(j) != sel && valid_in[j] && in_use[j] &&
				    (!was_valid || age_in[j] < sel_age) &&
				    (5'(age_in[j]) + 5'd1 < ctl.ways)) begin
					age_out[j] = age_in[j] + AGE_W'(1);
				end
			end
			age_out[sel]   = '0;
			valid_out[sel] = 1'b1;
			if (!hit) begin
				tag_out[sel] = tag;
			end
		end
	end
endmodule

/* sv/set_assoc_cache_directory_prefetch.sv */
// top level of the set-associative cache tag directory with next-line prefetch
`timescale 1ns / 1ps
// Tag directory for a write-through, write-allocate cache. A read or write
// word is taken when start is high and busy low; its result appears on
// hit, mem_reads and mem_write for one cycle with done high, and must be
// taken then. A directory row per set (valid, tag and age of every way) sits
// in one ram with a registered read; each lookup reads the row, updates it and
// writes it back. A demand miss with prefetch enabled also looks up the next
// block (a second row read; the demand row is forwarded when both fall in the
// same set). A clear request rewrites all NUM_SETS rows, one per cycle, and the
// same pass runs after reset with busy high.
// Configuration writes are taken only while the block is idle and start is low.
module set_assoc_cache_directory_prefetch #(
	parameter int NUM_SETS  = 64,
	parameter int WAYS      = 8,
	parameter int ADDR_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [ADDR_BITS-1:0] address,
	output logic                 done,
	output logic                 hit,
	output logic [1:0]           mem_reads,
	output logic                 mem_write,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [3:0]           cfg_data
);
	localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W  = WAYS * (1 + ADDR_BITS + AGE_W);

	sacd_pkg::state_t state_q;
	logic [SET_AW-1:0] sweep_q;
	logic              clr_pend_q;

	logic [3:0] offset_bits_q;
	logic [2:0] set_bits_q;
	logic [3:0] ways_in_use_q;
	logic       lru_mode_q;
	logic       prefetch_q;

	logic [1:0]           type_s1;
	logic [SET_AW-1:0]    dset_s1;
	logic [ADDR_BITS-1:0] dtag_s1;
	logic [ADDR_BITS-1:0] naddr_s1;
	logic [SET_AW-1:0]    pset_s2;
	logic [ADDR_BITS-1:0] ptag_s2;
	logic [ROW_W-1:0]     wrow_q;

	logic       done_q;
	logic       hit_q;
	logic [1:0] reads_q;
	logic       wr_q;

	logic [SET_AW-1:0] mod_tab [128];

	logic              accept;
	logic [SET_AW-1:0] dset_c;
	logic [SET_AW-1:0] pset_c;
	logic [ADDR_BITS-1:0] ptag_c;
	logic [4:0]        eff_ways;

	logic              ram_we;
	logic [SET_AW-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [SET_AW-1:0] ram_raddr;
	logic [ROW_W-1:0]  ram_rdata;

	logic [ROW_W-1:0]  row_in;
	logic [ROW_W-1:0]  row_out;
	logic [ADDR_BITS-1:0] lkp_tag;
	sacd_pkg::lkp_ctl_t lkp_ctl;
	logic              lkp_hit;

	logic [WAYS-1:0]                v_in;
	logic [WAYS-1:0][ADDR_BITS-1:0] t_in;
	logic [WAYS-1:0][AGE_W-1:0]     a_in;
	logic [WAYS-1:0]                v_out;
	logic [WAYS-1:0][ADDR_BITS-1:0] t_out;
	logic [WAYS-1:0][AGE_W-1:0]     a_out;

	// masked set index is below 128, so its wrap into the array is a table
	for (genvar g = 0; g < 128; g++) begin : g_mod
		assign mod_tab[g] = SET_AW'(g % NUM_SETS);
	end

	function automatic logic [6:0] raw_set(input logic [ADDR_BITS-1:0] a,
	                                      input logic [3:0] off,
	                                      input logic [2:0] sb);
		logic [ADDR_BITS-1:0] sh;
		sh = a >> off;
		return sh[6:0] & 7'((8'd1 << sb) - 8'd1);
	endfunction

	function automatic logic [ADDR_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] a,
	                                             input logic [3:0] off,
	                                             input logic [2:0] sb);
		return a >> (5'(off) + 5'(sb));
	endfunction

	assign accept    = start && (state_q == sacd_pkg::ST_IDLE);
	assign busy      = (state_q != sacd_pkg::ST_IDLE);
	assign cfg_ready = (state_q == sacd_pkg::ST_IDLE) && !start;
	assign dset_c    = mod_tab[raw_set(address, offset_bits_q, set_bits_q)];
	assign pset_c    = mod_tab[raw_set(naddr_s1, offset_bits_q, set_bits_q)];
	assign ptag_c    = tag_of(naddr_s1, offset_bits_q, set_bits_q);

	always_comb begin
		if (ways_in_use_q == 4'd0) begin
			eff_ways = 5'd1;
		end else if (5'(ways_in_use_q) > 5'(WAYS)) begin
			eff_ways = 5'(WAYS);
		end else begin
			eff_ways = 5'(ways_in_use_q);
		end
	end

	// lookup input: the prefetch row is forwarded when it is the row just written
	always_comb begin
		if (state_q == sacd_pkg::ST_PLOOK) begin
			row_in  = (pset_s2 == dset_s1) ? wrow_q : ram_rdata;
			lkp_tag = ptag_s2;
		end else begin
			row_in  = ram_rdata;
			lkp_tag = dtag_s1;
		end
		lkp_ctl.refresh = (state_q == sacd_pkg::ST_LOOK) && lru_mode_q;
		lkp_ctl.ways    = eff_ways;
		{a_in, t_in, v_in} = row_in;
	end

	sacd_way_update #(
		.WAYS      (WAYS),
		.ADDR_BITS (ADDR_BITS),
		.AGE_W     (AGE_W)
	) u_upd (
		.ctl       (lkp_ctl),
		.tag       (lkp_tag),
		.valid_in  (v_in),
		.tag_in    (t_in),
		.age_in    (a_in),
		.hit       (lkp_hit),
		.valid_out (v_out),
		.tag_out   (t_out),
		.age_out   (a_out)
	);

	assign row_out = {a_out, t_out, v_out};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dset_s1;
		ram_wdata = row_out;
		ram_re    = accept || (state_q == sacd_pkg::ST_LOOK);
		ram_raddr = (state_q == sacd_pkg::ST_LOOK) ? pset_c : dset_c;
		unique case (state_q)
			sacd_pkg::ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = '0;
			end
			sacd_pkg::ST_LOOK: begin
				ram_we = 1'b1;
			end
			sacd_pkg::ST_PLOOK: begin
				ram_we    = 1'b1;
				ram_waddr = pset_s2;
			end
			default: begin
			end
		endcase
	end

	sacd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_dir (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 4'd5;
			set_bits_q    <= 3'd0;
			ways_in_use_q <= 4'd8;
			lru_mode_q    <= 1'b0;
			prefetch_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sacd_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				sacd_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data[2:0];
				sacd_pkg::CFG_WAYS:        ways_in_use_q <= cfg_data;
				sacd_pkg::CFG_LRU:         lru_mode_q    <= cfg_data[0];
				sacd_pkg::CFG_PREFETCH:    prefetch_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sacd_pkg::ST_SWEEP;
			sweep_q    <= '0;
			clr_pend_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				sacd_pkg::ST_SWEEP: begin
					sweep_q <= sweep_q + SET_AW'(1);
					if (sweep_q == SET_AW'(NUM_SETS - 1)) begin
						state_q    <= sacd_pkg::ST_IDLE;
						done_q     <= clr_pend_q;
						clr_pend_q <= 1'b0;
					end
				end
				sacd_pkg::ST_IDLE: begin
					if (start) begin
						case (req_type)
							sacd_pkg::REQ_READ, sacd_pkg::REQ_WRITE: begin
								state_q <= sacd_pkg::ST_LOOK;
							end
							sacd_pkg::REQ_CLEAR: begin
								state_q    <= sacd_pkg::ST_SWEEP;
								sweep_q    <= '0;
								clr_pend_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				sacd_pkg::ST_LOOK: begin
					if (!lkp_hit && prefetch_q) begin
						state_q <= sacd_pkg::ST_PLOOK;
					end else begin
						state_q <= sacd_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				sacd_pkg::ST_PLOOK: begin
					state_q <= sacd_pkg::ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= sacd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1  <= req_type;
			dset_s1  <= dset_c;
			dtag_s1  <= tag_of(address, offset_bits_q, set_bits_q);
			naddr_s1 <= address + (ADDR_BITS'(1) << offset_bits_q);
			hit_q    <= 1'b0;
			reads_q  <= 2'd0;
			wr_q     <= 1'b0;
		end
		unique case (state_q)
			sacd_pkg::ST_SWEEP: begin
				hit_q   <= 1'b0;
				reads_q <= 2'd0;
				wr_q    <= 1'b0;
			end
			sacd_pkg::ST_LOOK: begin
				pset_s2 <= pset_c;
				ptag_s2 <= ptag_c;
				wrow_q  <= row_out;
				hit_q   <= lkp_hit;
				reads_q <= lkp_hit ? 2'd0 : 2'd1;
				wr_q    <= (type_s1 == sacd_pkg::REQ_WRITE);
			end
			sacd_pkg::ST_PLOOK: begin
				reads_q <= lkp_hit ? 2'd1 : 2'd2;
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign hit       = hit_q;
	assign mem_reads = reads_q;
	assign mem_write = wr_q;
endmodule

/* sv/sacd_checker.sv */
// port-level checks for the cache tag directory, bound to the top level
`timescale 1ns / 1ps
module sacd_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] req_type,
	input logic       done,
	input logic       hit,
	input logic [1:0] mem_reads,
	input logic       mem_write
);
	// a taken word either keeps the block busy or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted word neither busy nor answered");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_hit_no_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (mem_reads == 2'd0))
		else $error("hit with memory reads");

	a_miss_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit && mem_write) |-> (mem_reads != 2'd0))
		else $error("write miss without a fill");

	// a read answers without a memory write after one lookup, or after a second one for the prefetch
	a_read_access: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == sacd_pkg::REQ_READ) |=>
		busy ##1 ((done && !mem_write) or (busy ##1 (done && !mem_write))))
		else $error("read access reported a memory write");
endmodule

bind set_assoc_cache_directory_prefetch sacd_port_checks u_sacd_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.req_type  (req_type),
	.done      (done),
	.hit       (hit),
	.mem_reads (mem_reads),
	.mem_write (mem_write)
);
